FILE: rtl/core/tkst_pkg.sv
// Shared types, op codes and defaults for the top-K sorted insert table.
`timescale 1ns / 1ps
package tkst_pkg;

  // Default number of table cells
  localparam int DEPTH_DEF = 16;

  // Field widths fixed by the interface
  localparam int TAG_W   = 64;
  localparam int LINES_W = 20;
  localparam int SCORE_W = 31;
  localparam int OP_W    = 2;
  localparam int RANK_W  = 4;
  localparam int CNT_W   = 5;

  // Reset value of the max_entries register
  localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = CNT_W'(10);

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // One table entry
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [LINES_W-1:0] lines;
    logic [SCORE_W-1:0] score;
  } entry_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic   add;
    entry_t ent;
  } cell_cmd_t;

endpackage

FILE: rtl/core/tkst_cell.sv
// One compare-and-shift cell of the sorted table.
`timescale 1ns / 1ps
module tkst_cell
  import tkst_pkg::*;
(
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  logic      valid,     // this slot lies below the current count
  input  logic      prev_ge,   // neighbour above keeps its place
  input  entry_t    prev_ent,  // entry held by the neighbour above
  output logic      ge,        // this cell keeps its place on an add
  output logic      ins,       // new word lands in this cell
  output entry_t    ent
);

  entry_t ent_r;
  entry_t ent_nxt;

  // Stored entry ranks ahead of (or ties with) the new one
  assign ge  = valid && (ent_r.score >= cmd.ent.score);
  assign ins = prev_ge && !ge;
  assign ent = ent_r;

  // Keep, take the new word, or take the neighbour's entry
  always_comb begin
    ent_nxt = ent_r;
    if (cmd.add && !ge) begin
      if (prev_ge) begin
        ent_nxt = cmd.ent;
      end else begin
        ent_nxt = prev_ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

FILE: rtl/core/tkst_pos_enc.sv
// Encodes the one-hot insert flags of the cell row into a placement.
`timescale 1ns / 1ps
module tkst_pos_enc
  import tkst_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int PW    = $clog2(DEPTH + 1)
)
(
  input  logic [DEPTH-1:0] flags,
  output logic [PW-1:0]    pos
);

  logic [PW-1:0] enc;

  // OR tree per output bit; at most one flag is set
  always_comb begin
    enc = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (flags[i]) begin
        enc = enc | PW'(i);
      end
    end
  end

  // No flag: every stored entry ranks ahead, so the slot is DEPTH
  assign pos = (|flags) ? enc : PW'(DEPTH);

endmodule

FILE: rtl/core/top_k_sorted_insert_table_top.sv
// Top level of the top-K sorted insert table: cell row, control and result register.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------------
//  input    | start, busy           | in_op, in_entry_tag, in_entry_lines,
//           |                       | in_entry_score, in_read_rank
//  result   | out_valid (strobe)    | out_kept, out_rank, out_count, out_tag,
//           |                       | out_lines, out_score
//  config   | cfg_we                | cfg_max_entries
//
// The row of cells compares and shifts in the cycle the word is accepted, and the
// result shows on the out_ ports in the next cycle and stays there until the next
// accepted word. busy stays low, so a new word may follow in every cycle.
// Synchronous active-low reset empties the table and loads max_entries with 10;
// entry contents are not cleared. The receiver cannot stall the result strobe.
`timescale 1ns / 1ps
module top_k_sorted_insert_table_top
  import tkst_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
)
(
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    in_op,
  input  logic [TAG_W-1:0]   in_entry_tag,
  input  logic [LINES_W-1:0] in_entry_lines,
  input  logic [SCORE_W-1:0] in_entry_score,
  input  logic [RANK_W-1:0]  in_read_rank,
  // configuration
  input  logic               cfg_we,
  input  logic [CNT_W-1:0]   cfg_max_entries,
  // result channel
  output logic               out_valid,
  output logic               out_kept,
  output logic [RANK_W-1:0]  out_rank,
  output logic [CNT_W-1:0]   out_count,
  output logic [TAG_W-1:0]   out_tag,
  output logic [LINES_W-1:0] out_lines,
  output logic [SCORE_W-1:0] out_score
);

  localparam int CW = $clog2(DEPTH + 1);  // table count
  localparam int PW = $clog2(DEPTH + 1);  // placement, may equal DEPTH
  localparam int IW = $clog2(DEPTH);      // cell index
  localparam int XW = 10;                 // common compare width

  logic            accept;
  op_t             op;
  cell_cmd_t       cmd;

  logic [CNT_W-1:0] max_r;
  logic [CW-1:0]    cnt_r;
  logic [CW-1:0]    cnt_nxt;

  logic [DEPTH-1:0] ge;
  logic [DEPTH-1:0] ins;
  logic [DEPTH-1:0] valid;
  entry_t           cell_ent [DEPTH];
  logic [PW-1:0]    pos;

  logic [XW-1:0] cnt_x, max_x, lim_x, inc_x, ncnt_x, pos_x, rr_x;
  logic [IW-1:0] rd_idx;
  entry_t        rd_ent;

  logic               out_valid_r;
  logic               kept_r, kept_nxt;
  logic [RANK_W-1:0]  rank_r, rank_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  entry_t             oent_r, oent_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign op     = op_t'(in_op);

  // Command broadcast along the row
  assign cmd.add       = accept && (op == OP_ADD);
  assign cmd.ent.tag   = in_entry_tag;
  assign cmd.ent.lines = in_entry_lines;
  assign cmd.ent.score = in_entry_score;

  // Row of cells; cell 0 sees an always-ahead neighbour
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign valid[i] = XW'(i) < cnt_x;
    if (i == 0) begin : g_head
      tkst_cell u_cell (
        .clk      (clk),
        .cmd      (cmd),
        .valid    (valid[i]),
        .prev_ge  (1'b1),
        .prev_ent (cmd.ent),
        .ge       (ge[i]),
        .ins      (ins[i]),
        .ent      (cell_ent[i])
      );
    end else begin : g_body
      tkst_cell u_cell (
        .clk      (clk),
        .cmd      (cmd),
        .valid    (valid[i]),
        .prev_ge  (ge[i-1]),
        .prev_ent (cell_ent[i-1]),
        .ge       (ge[i]),
        .ins      (ins[i]),
        .ent      (cell_ent[i])
      );
    end
  end

  tkst_pos_enc #(
    .DEPTH (DEPTH),
    .PW    (PW)
  ) u_pos_enc (
    .flags (ins),
    .pos   (pos)
  );

  // Limit and new count after an add
  assign cnt_x  = XW'(cnt_r);
  assign max_x  = XW'(max_r);
  assign lim_x  = (max_x == '0) ? XW'(1) :
                  (max_x > XW'(DEPTH)) ? XW'(DEPTH) : max_x;
  assign inc_x  = cnt_x + XW'(1);
  assign ncnt_x = (inc_x > lim_x) ? lim_x : inc_x;
  assign pos_x  = XW'(pos);

  // Read port of the row
  assign rr_x   = XW'(in_read_rank);
  assign rd_idx = rr_x[IW-1:0];
  assign rd_ent = cell_ent[rd_idx];

  // Next count and result word
  always_comb begin
    cnt_nxt   = cnt_r;
    kept_nxt  = 1'b0;
    rank_nxt  = '0;
    oent_nxt  = '0;
    count_nxt = cnt_x[CNT_W-1:0];
    case (op)
      OP_ADD: begin
        cnt_nxt   = ncnt_x[CW-1:0];
        kept_nxt  = pos_x < ncnt_x;
        rank_nxt  = (pos_x > XW'(15)) ? RANK_W'(15) : pos_x[RANK_W-1:0];
        count_nxt = ncnt_x[CNT_W-1:0];
      end
      OP_READ: begin
        rank_nxt = in_read_rank;
        if (rr_x < cnt_x) begin
          kept_nxt = 1'b1;
          oent_nxt = rd_ent;
        end
      end
      OP_CLEAR: begin
        cnt_nxt   = '0;
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      max_r       <= MAX_ENTRIES_RST;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
      if (cfg_we) begin
        max_r <= cfg_max_entries;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (accept) begin
      kept_r  <= kept_nxt;
      rank_r  <= rank_nxt;
      count_r <= count_nxt;
      oent_r  <= oent_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kept  = kept_r;
  assign out_rank  = rank_r;
  assign out_count = count_r;
  assign out_tag   = oent_r.tag;
  assign out_lines = oent_r.lines;
  assign out_score = oent_r.score;

`ifndef SYNTHESIS
  // Table never holds more than its cells
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_x <= XW'(DEPTH))
    else $error("entry count beyond depth");

  // One result strobe per accepted word, in the cycle after it
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("result strobe missing");

  // A clear leaves an empty table and a bare result
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op == OP_CLEAR) |=> (cnt_r == '0 && out_count == '0 && !out_kept))
    else $error("clear did not empty the table");

  // An add always leaves at least one entry
  a_add_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op == OP_ADD) |=> (cnt_r != '0))
    else $error("add left an empty table");
`endif

endmodule
